/* design/ptu_pkg.sv */
`default_nettype none

package ptu_pkg;

  localparam int unsigned ByteBits    = 8;
  localparam int unsigned CfgWidth    = 3;
  localparam int unsigned CountWidth  = 3;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned TrapWidth   = 16;
  localparam int unsigned OutBits     = 2 * WordWidth + TrapWidth;

  localparam logic [ByteBits-1:0]   EscByte     = 8'd255;
  localparam logic [ByteBits-1:0]   SetEndByte  = 8'd254;
  localparam logic [CfgWidth-1:0]   CondLenMin  = 3'd1;
  localparam logic [CfgWidth-1:0]   CondLenMax  = 3'd4;
  localparam logic [CfgWidth-1:0]   CondReset   = 3'd1;

  localparam logic ResultEntry = 1'b0;
  localparam logic ResultEnd   = 1'b1;

  typedef enum logic [6:0] {
    PH_DONE    = 7'b0000001,
    PH_COND    = 7'b0000010,
    PH_DELTA   = 7'b0000100,
    PH_ESC_HI  = 7'b0001000,
    PH_ESC_LO  = 7'b0010000,
    PH_TRAP_HI = 7'b0100000,
    PH_TRAP_LO = 7'b1000000
  } phase_t;

  function automatic logic [CountWidth-1:0] cond_len(input logic [CfgWidth-1:0] cfg);
    logic [CountWidth-1:0] len;
    len = cfg;
    if (cfg == '0) begin
      len = CondLenMin;
    end else if (cfg > CondLenMax) begin
      len = CondLenMax;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* design/patch_table_unpacker_top.sv */
`default_nettype none

// Channel  Direction  tdata                                         tuser
// s_*      in         data_byte[7:0]                                table_start
// m_*      out        condition_set, jump_table_offset, trap_word   result_kind
// cfg_*    in         condition_bytes[2:0] (write only)             -
//
// One byte is taken per cycle; the parser state updates in the cycle of acceptance.
// A result appears in the output register on the cycle after its closing byte.
// Input stalls only while a result waits in the output register and is not taken.
// Reset clears the parser to the finished state and sets condition_bytes to one.
module patch_table_unpacker_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [7:0]                    s_tdata,   // data_byte
  input  wire logic                          s_tuser,   // table_start
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  output      logic [ptu_pkg::OutBits-1:0]   m_tdata,   // condition_set, jump_table_offset, trap_word
  output      logic                          m_tuser,   // result_kind
  input  wire logic                          cfg_we,
  input  wire logic [ptu_pkg::CfgWidth-1:0]  cfg_data
);

  import ptu_pkg::*;

  logic [CfgWidth-1:0]   condition_bytes;
  phase_t                phase, phase_next;
  logic [CountWidth-1:0] cond_count, cond_count_next;
  logic [WordWidth-1:0]  cond_accum, cond_accum_next;
  logic [WordWidth-1:0]  offset_accum, offset_accum_next;
  logic [ByteBits-1:0]   delta_high, delta_high_next;
  logic [ByteBits-1:0]   trap_high, trap_high_next;
  logic                  res_valid;
  logic                  res_kind;
  logic [OutBits-1:0]    res_data;
  logic                  accept;
  logic [CountWidth-1:0] count_inc;
  logic [2*ByteBits-1:0] esc_delta;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign esc_delta = {delta_high, s_tdata};

  always_comb begin
    phase_next        = phase;
    cond_count_next   = cond_count;
    cond_accum_next   = cond_accum;
    offset_accum_next = offset_accum;
    delta_high_next   = delta_high;
    trap_high_next    = trap_high;
    res_valid         = 1'b0;
    res_kind          = ResultEntry;
    res_data          = '0;
    count_inc         = '0;
    if (s_tuser || phase == PH_COND) begin
      count_inc       = (s_tuser ? '0 : cond_count) + 1'b1;
      cond_accum_next = {(s_tuser ? '0 : cond_accum[WordWidth-ByteBits-1:0]), s_tdata};
      cond_count_next = count_inc;
      phase_next      = (count_inc >= cond_len(condition_bytes)) ? PH_DELTA : PH_COND;
      if (s_tuser) begin
        offset_accum_next = '0;
        delta_high_next   = '0;
        trap_high_next    = '0;
      end
    end else begin
      unique case (phase)
        PH_DELTA: begin
          if (s_tdata == EscByte) begin
            phase_next = PH_ESC_HI;
          end else if (s_tdata == SetEndByte) begin
            cond_accum_next = '0;
            cond_count_next = '0;
            phase_next      = PH_COND;
          end else begin
            offset_accum_next = offset_accum + WordWidth'(s_tdata);
            phase_next        = PH_TRAP_HI;
          end
        end
        PH_ESC_HI: begin
          delta_high_next = s_tdata;
          phase_next      = PH_ESC_LO;
        end
        PH_ESC_LO: begin
          if (esc_delta == '0) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res_kind   = ResultEnd;
          end else begin
            offset_accum_next = offset_accum + WordWidth'(esc_delta);
            phase_next        = PH_TRAP_HI;
          end
        end
        PH_TRAP_HI: begin
          trap_high_next = s_tdata;
          phase_next     = PH_TRAP_LO;
        end
        PH_TRAP_LO: begin
          phase_next = PH_DELTA;
          res_valid  = 1'b1;
          res_data   = {trap_high, s_tdata, offset_accum, cond_accum};
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      condition_bytes <= CondReset;
    end else if (cfg_we) begin
      condition_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DONE;
      cond_count   <= '0;
      cond_accum   <= '0;
      offset_accum <= '0;
      delta_high   <= '0;
      trap_high    <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      cond_count   <= cond_count_next;
      cond_accum   <= cond_accum_next;
      offset_accum <= offset_accum_next;
      delta_high   <= delta_high_next;
      trap_high    <= trap_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      m_tdata <= res_data;
      m_tuser <= res_kind;
    end
  end

  // The end marker carries an all-zero payload.
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ResultEnd) |-> (m_tdata == '0))
    else $error("end marker with non-zero payload");

  // An end result always leaves the parser finished.
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res_kind == ResultEnd) |=> (phase == PH_DONE))
    else $error("parser not finished after end marker");

  // A start byte always clears the running offset.
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |=> (offset_accum == '0))
    else $error("offset not cleared on table start");

  // Ignored bytes leave the parser state untouched.
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser && phase == PH_DONE) |=>
      (phase == PH_DONE && $stable(offset_accum) && !(m_tvalid && !$past(m_tvalid))))
    else $error("state changed by an ignored byte");

  // The condition byte count never exceeds the longest condition word.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cond_count <= CondLenMax)
    else $error("condition byte count out of range");

endmodule

`default_nettype wire
